// File: rtl/ntcdt_pkg.sv
// Shared constants, resistance table, codes and control structs for the NTC lookup.
package ntcdt_pkg;

  localparam int TABLE_ENTRIES = 206;
  localparam int RES_FRAC_BITS = 4;

  localparam int ADC_W     = 16;
  localparam int SUPPLY_W  = 16;
  localparam int RF_OHM_W  = 20;
  localparam int TEMP_W    = 16;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  // Fixed-point resistance widths
  localparam int RES_W   = 21 + RES_FRAC_BITS;
  localparam int RF_W    = RF_OHM_W + RES_FRAC_BITS;
  localparam int MUL_B_W = RES_W + 1;
  localparam int PROD_W  = ADC_W + MUL_B_W;
  localparam int R_W     = RF_W + ADC_W;
  localparam int DEN_W   = RES_W;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int POS_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_W   = $clog2(R_W + 1);
  localparam int SHORT_BITS = 4;

  localparam int TEMP_BASE = -550;
  localparam int TEMP_STEP = 10;

  localparam logic [SUPPLY_W-1:0] SUPPLY_RST = SUPPLY_W'(3300);
  localparam logic [RF_OHM_W-1:0] RF_OHM_RST = RF_OHM_W'(10000);

  localparam logic [TEMP_W-1:0] TEMP_SENT_LOW  = 16'h8000;
  localparam logic [TEMP_W-1:0] TEMP_SENT_HIGH = 16'h7FFF;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_V_HIGH  = 2'd1,
    ST_V_LOW   = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY = 2'd0,
    CFG_RF     = 2'd1,
    CFG_UPPER  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_VR0,
    MUL_VRN,
    MUL_SRF,
    MUL_SR0,
    MUL_SRN,
    MUL_RFN
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_en;
    mul_op_t mul_op;
    logic    div_full;
    logic    div_short;
    logic    r_load;
    logic    srch_init;
    logic    srch_step;
    logic    temp_load;
    logic    temp_interp;
    logic    out_load;
    status_t kind;
  } cmd_t;

  typedef struct packed {
    logic too_high;
    logic too_low;
    logic den_zero;
    logic div_busy;
    logic found;
    logic srch_done;
    logic last_idx;
    logic direct;
  } sts_t;

  // Resistance in tenths of an ohm, -55 C to +150 C in 1 C steps
  typedef logic [31:0] tenths_arr_t [TABLE_ENTRIES];
  localparam tenths_arr_t LUT_TENTHS = '{
    9089738, 8450100, 7859550, 7314032, 6809845, 6343613,
    5912255, 5512957, 5143148, 4800477, 4482794, 4188129,
    3914681, 3660799, 3424968, 3205801, 3002022, 2812464,
    2636050, 2471794, 2318789, 2176198, 2043253, 1919247,
    1803527, 1695493, 1594590, 1500308, 1412173, 1329751,
    1252639, 1180465, 1112885, 1049582, 990259, 934646,
    882488, 833553, 787623, 744497, 703989, 665924,
    630143, 596496, 564843, 535056, 507014, 480606,
    455728, 432283, 410179, 389335, 369670, 351112,
    333593, 317048, 301419, 286650, 272689, 259488,
    247001, 235185, 224002, 213414, 203386, 193885,
    184882, 176347, 168254, 160578, 153294, 146382,
    139819, 133587, 127667, 122042, 116696, 111613,
    106779, 102182, 97805, 93634, 89659, 85878,
    82274, 78844, 75571, 72456, 69483, 66651,
    63946, 61365, 58905, 56554, 54310, 52166,
    50121, 48164, 46294, 44506, 42797, 41165,
    39601, 38104, 36672, 35302, 33989, 32732,
    31528, 30375, 29269, 28210, 27194, 26220,
    25286, 24390, 23530, 22705, 21913, 21152,
    20422, 19719, 19045, 18398, 17776, 17178,
    16602, 16049, 15517, 15006, 14513, 14039,
    13583, 13144, 12721, 12315, 11922, 11545,
    11181, 10830, 10492, 10164, 9847, 9542,
    9248, 8964, 8691, 8427, 8172, 7926,
    7689, 7459, 7238, 7025, 6818, 6619,
    6426, 6240, 6060, 5887, 5719, 5556,
    5399, 5247, 5100, 4958, 4820, 4687,
    4558, 4434, 4313, 4196, 4083, 3973,
    3867, 3764, 3664, 3567, 3474, 3383,
    3295, 3210, 3127, 3047, 2969, 2893,
    2820, 2749, 2680, 2613, 2548, 2485,
    2424, 2364, 2306, 2250, 2196, 2143,
    2091, 2041, 1993, 1945, 1899, 1855,
    1811, 1769
  };

  typedef logic [RES_W-1:0] res_arr_t [TABLE_ENTRIES];

  // Scale tenths of an ohm to the fixed-point grid, rounded to nearest
  function automatic res_arr_t build_res();
    res_arr_t t;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      t[i] = RES_W'(((64'(LUT_TENTHS[i]) << RES_FRAC_BITS) + 64'd5) / 64'd10);
    end
    return t;
  endfunction

  localparam res_arr_t LUT_RES = build_res();

endpackage

// File: rtl/ntcdt_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle, full or short run.
module ntcdt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_full,
  input  logic                         load_short,
  input  logic [ntcdt_pkg::R_W-1:0]    num,
  input  logic [ntcdt_pkg::DEN_W-1:0]  den,
  output logic                         busy,
  output logic [ntcdt_pkg::R_W-1:0]    quo,
  output logic [ntcdt_pkg::DEN_W-1:0]  rem
);

  localparam int RW = ntcdt_pkg::R_W;
  localparam int DW = ntcdt_pkg::DEN_W;
  localparam int SB = ntcdt_pkg::SHORT_BITS;

  logic [ntcdt_pkg::CNT_W-1:0] cnt;
  logic [RW-1:0]               sh;
  logic [DW-1:0]               den_q;
  logic [DW:0]                 trial;
  logic                        fits;

  assign busy  = (cnt != '0);
  assign trial = {rem, sh[RW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  // Iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load_full) begin
      cnt <= ntcdt_pkg::CNT_W'(RW);
    end else if (load_short) begin
      cnt <= ntcdt_pkg::CNT_W'(SB);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Shift in one numerator bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (load_full) begin
      rem   <= '0;
      sh    <= num;
      quo   <= '0;
      den_q <= den;
    end else if (load_short) begin
      // quotient below 2^SB: upper numerator bits already lie below the divisor
      rem   <= num[SB +: DW];
      sh    <= {num[SB-1:0], {(RW-SB){1'b0}}};
      quo   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      sh  <= {sh[RW-2:0], 1'b0};
      quo <= {quo[RW-2:0], fits};
    end
  end

endmodule

// File: rtl/ntcdt_dp.sv
// Datapath: config registers, shared multiplier, divider, table search and interpolation.
module ntcdt_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [ntcdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntcdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [ntcdt_pkg::ADC_W-1:0]       adc_mv,
  input  ntcdt_pkg::cmd_t                   cmd,
  output ntcdt_pkg::sts_t                   sts,
  output logic [ntcdt_pkg::TEMP_W-1:0]      out_temp,
  output logic [ntcdt_pkg::STAT_W-1:0]      out_status
);

  localparam int N   = ntcdt_pkg::TABLE_ENTRIES;
  localparam int RW  = ntcdt_pkg::R_W;
  localparam int ESW = ntcdt_pkg::RES_W;
  localparam int PW  = ntcdt_pkg::PROD_W;
  localparam int PSW = ntcdt_pkg::POS_W;
  localparam int IW  = ntcdt_pkg::IDX_W;
  localparam int TW  = ntcdt_pkg::TEMP_W;
  localparam logic [ESW-1:0] R0 = ntcdt_pkg::LUT_RES[0];
  localparam logic [ESW-1:0] RN = ntcdt_pkg::LUT_RES[N-1];

  logic [ntcdt_pkg::SUPPLY_W-1:0] supply;
  logic [ntcdt_pkg::RF_OHM_W-1:0] rf_ohm;
  logic                           upper;
  logic [ntcdt_pkg::ADC_W-1:0]    v;
  logic [ntcdt_pkg::RF_W-1:0]     rf;

  logic [ntcdt_pkg::ADC_W-1:0]    mul_a;
  logic [ntcdt_pkg::MUL_B_W-1:0]  mul_b;
  logic [PW-1:0]                  prod;
  logic [PW-1:0] p_vr0, p_vrn, p_srf, p_sr0, p_srn, p_rfn;

  logic [ntcdt_pkg::ADC_W-1:0]    diff, num, den;

  logic [RW-1:0]                  r;
  logic [PSW-1:0]                 lo, hi, lo1;
  logic [PSW:0]                   mid_sum;
  logic [PSW-1:0]                 mid;
  logic [ESW-1:0]                 lut_mid, rh, rl, d;
  logic [ESW+3:0]                 ten_d;

  logic                           div_load_full, div_load_short, div_busy;
  logic [RW-1:0]                  div_num, div_quo;
  logic [ntcdt_pkg::DEN_W-1:0]    div_den, div_rem;

  logic [TW-1:0]                  tl, temp_i, temp;
  logic                           adj;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= ntcdt_pkg::SUPPLY_RST;
      rf_ohm <= ntcdt_pkg::RF_OHM_RST;
      upper  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ntcdt_pkg::CFG_SUPPLY: supply <= cfg_data[ntcdt_pkg::SUPPLY_W-1:0];
        ntcdt_pkg::CFG_RF:     rf_ohm <= cfg_data;
        ntcdt_pkg::CFG_UPPER:  upper  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rf = ntcdt_pkg::RF_W'(rf_ohm) << ntcdt_pkg::RES_FRAC_BITS;

  // Divider operands from the voltages
  assign diff = (supply > v) ? supply - v : '0;
  assign num  = upper ? diff : v;
  assign den  = upper ? v : diff;

  // Shared multiplier operand select
  always_comb begin
    mul_a = v;
    mul_b = '0;
    case (cmd.mul_op)
      ntcdt_pkg::MUL_VR0: mul_b = ntcdt_pkg::MUL_B_W'(R0) + ntcdt_pkg::MUL_B_W'(rf);
      ntcdt_pkg::MUL_VRN: mul_b = ntcdt_pkg::MUL_B_W'(RN) + ntcdt_pkg::MUL_B_W'(rf);
      ntcdt_pkg::MUL_SRF: begin
        mul_a = supply;
        mul_b = ntcdt_pkg::MUL_B_W'(rf);
      end
      ntcdt_pkg::MUL_SR0: begin
        mul_a = supply;
        mul_b = ntcdt_pkg::MUL_B_W'(R0);
      end
      ntcdt_pkg::MUL_SRN: begin
        mul_a = supply;
        mul_b = ntcdt_pkg::MUL_B_W'(RN);
      end
      ntcdt_pkg::MUL_RFN: begin
        mul_a = num;
        mul_b = ntcdt_pkg::MUL_B_W'(rf);
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // Capture sample and products
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v <= adc_mv;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_op)
        ntcdt_pkg::MUL_VR0: p_vr0 <= prod;
        ntcdt_pkg::MUL_VRN: p_vrn <= prod;
        ntcdt_pkg::MUL_SRF: p_srf <= prod;
        ntcdt_pkg::MUL_SR0: p_sr0 <= prod;
        ntcdt_pkg::MUL_SRN: p_srn <= prod;
        ntcdt_pkg::MUL_RFN: p_rfn <= prod;
        default: ;
      endcase
    end
  end

  // Voltage window as cross products
  assign sts.too_high = upper ? (p_vrn > p_srf) : (p_vr0 > p_sr0);
  assign sts.too_low  = upper ? (p_vr0 < p_srf) : (p_vrn < p_srn);
  assign sts.den_zero = (den == '0);

  // Divider shared by resistance and interpolation
  assign d     = r[ESW-1:0] - rl;
  assign ten_d = ((ESW + 4)'(d) << 3) + ((ESW + 4)'(d) << 1);

  assign div_load_full  = cmd.div_full;
  assign div_load_short = cmd.div_short;
  assign div_num = cmd.div_full ? p_rfn[RW-1:0] : RW'(ten_d);
  assign div_den = cmd.div_full ? ntcdt_pkg::DEN_W'(den) : ntcdt_pkg::DEN_W'(rh - rl);

  ntcdt_div u_div (
    .clk        (clk),
    .rst        (rst),
    .load_full  (div_load_full),
    .load_short (div_load_short),
    .num        (div_num),
    .den        (div_den),
    .busy       (div_busy),
    .quo        (div_quo),
    .rem        (div_rem)
  );

  assign sts.div_busy = div_busy;

  // Binary search for the last entry above r
  assign mid_sum = (PSW + 1)'(lo) + (PSW + 1)'(hi);
  assign mid     = mid_sum[PSW:1];
  assign lut_mid = ntcdt_pkg::LUT_RES[mid[IW-1:0]];
  assign lo1     = lo + 1'b1;
  assign rh      = ntcdt_pkg::LUT_RES[lo[IW-1:0]];
  assign rl      = ntcdt_pkg::LUT_RES[lo1[IW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.r_load) begin
      r <= div_quo;
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= PSW'(N);
    end else if (cmd.srch_step) begin
      if (RW'(lut_mid) > r) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
  end

  assign sts.found     = (RW'(R0) > r);
  assign sts.srch_done = (hi == lo1);
  assign sts.last_idx  = (lo == PSW'(N - 1));
  assign sts.direct    = (rh <= rl) || (r < RW'(rl));

  // Interpolate, truncating toward zero
  assign tl     = TW'(ntcdt_pkg::TEMP_BASE) + TW'(ntcdt_pkg::TEMP_STEP) * TW'(lo1);
  assign adj    = ($signed(tl) > $signed(TW'(0))) && (div_rem != '0);
  assign temp_i = tl - TW'(div_quo[ntcdt_pkg::SHORT_BITS-1:0]) - TW'(adj);

  always_ff @(posedge clk) begin
    if (cmd.temp_load) begin
      temp <= cmd.temp_interp ? temp_i : tl;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.kind;
      case (cmd.kind)
        ntcdt_pkg::ST_OK:     out_temp <= temp;
        ntcdt_pkg::ST_V_LOW:  out_temp <= ntcdt_pkg::TEMP_SENT_HIGH;
        default:              out_temp <= ntcdt_pkg::TEMP_SENT_LOW;
      endcase
    end
  end

endmodule

// File: rtl/ntcdt_ctrl.sv
// Controller: sequences multiply, check, divide, search and interpolate for one sample.
module ntcdt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  ntcdt_pkg::sts_t sts,
  output ntcdt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MA, S_MB, S_MC, S_MD, S_ME, S_CHK, S_MR,
    S_DLD, S_DWR, S_FND, S_SRCH, S_INT, S_DWT, S_DONE
  } state_t;

  state_t            state, state_next;
  ntcdt_pkg::status_t kind, kind_next;
  logic              out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    cmd.mul_op = ntcdt_pkg::MUL_VR0;
    cmd.kind   = kind;
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MA;
        end
      end
      S_MA: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ntcdt_pkg::MUL_VR0;
        state_next = S_MB;
      end
      S_MB: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ntcdt_pkg::MUL_VRN;
        state_next = S_MC;
      end
      S_MC: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ntcdt_pkg::MUL_SRF;
        state_next = S_MD;
      end
      S_MD: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ntcdt_pkg::MUL_SR0;
        state_next = S_ME;
      end
      S_ME: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ntcdt_pkg::MUL_SRN;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.too_high) begin
          kind_next  = ntcdt_pkg::ST_V_HIGH;
          state_next = S_DONE;
        end else if (sts.too_low) begin
          kind_next  = ntcdt_pkg::ST_V_LOW;
          state_next = S_DONE;
        end else if (sts.den_zero) begin
          kind_next  = ntcdt_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          state_next = S_MR;
        end
      end
      S_MR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ntcdt_pkg::MUL_RFN;
        state_next = S_DLD;
      end
      S_DLD: begin
        cmd.div_full = 1'b1;
        state_next   = S_DWR;
      end
      S_DWR: begin
        if (!sts.div_busy) begin
          cmd.r_load = 1'b1;
          state_next = S_FND;
        end
      end
      S_FND: begin
        if (!sts.found) begin
          kind_next  = ntcdt_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          state_next = S_INT;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_INT: begin
        if (sts.last_idx) begin
          kind_next  = ntcdt_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else if (sts.direct) begin
          cmd.temp_load = 1'b1;
          kind_next     = ntcdt_pkg::ST_OK;
          state_next    = S_DONE;
        end else begin
          cmd.div_short = 1'b1;
          state_next    = S_DWT;
        end
      end
      S_DWT: begin
        if (!sts.div_busy) begin
          cmd.temp_load   = 1'b1;
          cmd.temp_interp = 1'b1;
          kind_next       = ntcdt_pkg::ST_OK;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, result kind and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= ntcdt_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A divider load always starts a busy run
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_full || cmd.div_short) |=> sts.div_busy)
    else $error("divider not busy after load");

  // Never overwrite a result that has not been taken
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("output overwritten");

  // Search only steps while the bracket is still open
  a_srch_open: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_step |-> !sts.srch_done)
    else $error("search stepped past bracket");

  // A new sample is taken only while no other is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_MA))
    else $error("sample accepted out of sequence");

endmodule

// File: rtl/ntc_divider_temperature_lookup.sv
// Top level: NTC divider voltage to temperature with table interpolation.
// Sequence to the result register: a voltage outside the window or a zero divisor ends at the check;
// a resistance outside the table ends after the 40-step resistance division or the search; an in-range
// sample also passes a 7- or 8-step binary table search and a 4-step interpolation division.
// Throughput: one sample at a time; the next is accepted once the result is in the output
// register, which waits for an earlier result to be taken. Reset: synchronous, 3300 mV/10k/low.
module ntc_divider_temperature_lookup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ntcdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntcdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [15:0] adc_mv
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // [15:0] temp_dc
  output logic [1:0]                        m_tuser    // [1:0] status
);

  ntcdt_pkg::cmd_t cmd;
  ntcdt_pkg::sts_t sts;

  // Registers take writes at any time; host writes only while idle
  assign cfg_ready = 1'b1;

  ntcdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ntcdt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .adc_mv     (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_temp   (m_tdata),
    .out_status (m_tuser)
  );

endmodule

// File: tb/sv/ntc_lookup_checker.sv
// Checker for the NTC lookup: predicts temperature and status and compares results.
module ntc_lookup_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0]        temp;
    ntcdt_pkg::status_t stat;
  } reading_t;

  reading_t     readings_due[$];
  logic [15:0]  supply;
  logic [19:0]  rf_ohm;
  logic         upper;
  longint unsigned res_grid [ntcdt_pkg::TABLE_ENTRIES];

  // Build the fixed-point table once
  initial begin
    for (int i = 0; i < ntcdt_pkg::TABLE_ENTRIES; i++)
      res_grid[i] = ((longint'(ntcdt_pkg::LUT_TENTHS[i]) << ntcdt_pkg::RES_FRAC_BITS) + 5) / 10;
  end

  function automatic reading_t convert_mv(logic [15:0] adc);
    reading_t o;
    longint unsigned v, vs, rf, r0, rn, num, den, r, rh, rl;
    longint tl, q;
    int h;
    bit found;
    v = adc; vs = supply; rf = longint'(rf_ohm) << ntcdt_pkg::RES_FRAC_BITS;
    r0 = res_grid[0]; rn = res_grid[ntcdt_pkg::TABLE_ENTRIES-1];
    found = 0; h = 0;
    o.stat = ntcdt_pkg::ST_OK;
    if (upper) begin
      if (v * (rn + rf) > vs * rf) begin
        o.temp = ntcdt_pkg::TEMP_SENT_LOW; o.stat = ntcdt_pkg::ST_V_HIGH; return o;
      end
      if (v * (r0 + rf) < vs * rf) begin
        o.temp = ntcdt_pkg::TEMP_SENT_HIGH; o.stat = ntcdt_pkg::ST_V_LOW; return o;
      end
      num = vs > v ? vs - v : 0; den = v;
    end else begin
      if (v * (r0 + rf) > vs * r0) begin
        o.temp = ntcdt_pkg::TEMP_SENT_LOW; o.stat = ntcdt_pkg::ST_V_HIGH; return o;
      end
      if (v * (rn + rf) < vs * rn) begin
        o.temp = ntcdt_pkg::TEMP_SENT_HIGH; o.stat = ntcdt_pkg::ST_V_LOW; return o;
      end
      num = v; den = vs > v ? vs - v : 0;
    end
    o.temp = ntcdt_pkg::TEMP_SENT_LOW;
    if (den == 0) begin
      o.stat = ntcdt_pkg::ST_OUTSIDE; return o;
    end
    r = rf * num / den;
    for (int i = 0; i < ntcdt_pkg::TABLE_ENTRIES; i++)
      if (r < res_grid[i]) begin
        h = i; found = 1;
      end
    if (!found || h + 1 >= ntcdt_pkg::TABLE_ENTRIES) begin
      o.stat = ntcdt_pkg::ST_OUTSIDE; return o;
    end
    rh = res_grid[h]; rl = res_grid[h+1];
    tl = ntcdt_pkg::TEMP_BASE + ntcdt_pkg::TEMP_STEP * (h + 1);
    if (rh <= rl || r < rl) q = tl;
    else q = (tl * longint'(rh - rl) - 10 * longint'(r - rl)) / longint'(rh - rl);
    o.temp = q[15:0];
    return o;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk) begin
    reading_t want;
    int errs;
    errs = 0;
    if (rst) begin
      supply <= ntcdt_pkg::SUPPLY_RST; rf_ohm <= ntcdt_pkg::RF_OHM_RST; upper <= 1'b0;
      fail_count <= 0;
      pending <= 0;
      readings_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (ntcdt_pkg::cfg_idx_t'(cfg_index))
          ntcdt_pkg::CFG_SUPPLY: supply <= cfg_data[15:0];
          ntcdt_pkg::CFG_RF:     rf_ohm <= cfg_data;
          ntcdt_pkg::CFG_UPPER:  upper <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) readings_due.push_back(convert_mv(s_tdata));
      if (m_tvalid && m_tready) begin
        if (readings_due.size() == 0) begin
          $error("result with nothing expected: temp %0d status %0d",
                 $signed(m_tdata), m_tuser);
          errs++;
        end else begin
          want = readings_due.pop_front();
          if (want.temp !== m_tdata) begin
            $error("temp_dc: expected %0d, actual %0d",
                   $signed(want.temp), $signed(m_tdata));
            errs++;
          end
          if (want.stat !== m_tuser) begin
            $error("status: expected %0d, actual %0d", want.stat, m_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= readings_due.size();
    end
  end
endmodule

// File: tb/sv/tb_ntc_divider_temperature_lookup.sv
// Testbench top: stimulus, configuration phases and verdict for the NTC lookup.
module tb_ntc_divider_temperature_lookup;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;
  logic        s_tvalid, s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fail_count, pending;
  bit          want_hold;

  ntc_divider_temperature_lookup DUT (.*);

  ntc_lookup_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    int hold_left;
    bit held;
    m_tready = 1'b0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !held) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_reg(ntcdt_pkg::cfg_idx_t idx, logic [19:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_mv(logic [15:0] mv);
    s_tvalid <= 1'b1; s_tdata <= mv;
    do @(posedge clk); while (!s_tready);
  endtask

  // Idle the sender for a random gap now and then
  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_divider(logic [15:0] vs, logic [19:0] rf, logic up);
    drain();
    write_reg(ntcdt_pkg::CFG_SUPPLY, 20'(vs));
    write_reg(ntcdt_pkg::CFG_RF, rf);
    write_reg(ntcdt_pkg::CFG_UPPER, 20'(up));
  endtask

  // Voltage near the useful window: mostly spread across the supply
  function automatic logic [15:0] pick_mv(logic [15:0] vs);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 15));
      2: return vs - 16'($urandom_range(0, (vs > 16'd15) ? 15 : 32'(vs)));
      default: return 16'($urandom_range(0, 32'(vs)));
    endcase
  endfunction

  initial begin
    logic [15:0] vs_list [6];
    logic [19:0] rf_list [6];
    rst = 1'b1;
    want_hold = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0;
    vs_list = '{16'd3300, 16'd5000, 16'd65535, 16'd1, 16'd1200, 16'd33000};
    rf_list = '{20'd10000, 20'd1000000, 20'd1, 20'd4700, 20'd100000, 20'd2200};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes and window edges
    foreach (vs_list[k]) begin
      send_mv(vs_list[k]);
    end
    send_mv(16'd0); send_mv(16'hFFFF); send_mv(16'd1650); send_mv(16'd16);
    send_mv(16'd3299); send_mv(16'd3290); send_mv(16'd5); send_mv(16'h5555);
    send_mv(16'hAAAA);
    set_divider(16'd3300, 20'd10000, 1'b1);
    send_mv(16'd0); send_mv(16'd3300); send_mv(16'd1650); send_mv(16'd3295);
    send_mv(16'd8); send_mv(16'hFFFF);

    // Fill the block while the receiver holds off
    want_hold <= 1'b1;
    repeat (6) send_mv(16'd1650);

    // Random phases across divider settings, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      logic [15:0] vs;
      logic [19:0] rf;
      vs = (ph < 6) ? vs_list[ph] : 16'($urandom_range(1, 65535));
      rf = (ph < 6) ? rf_list[ph] : 20'($urandom_range(1, 1000000));
      set_divider(vs, rf, ph[0]);
      repeat (155) begin
        send_mv(pick_mv(vs));
        maybe_gap();
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
